### rtl/vidrt_pkg.sv
`timescale 1ns / 1ps

package vidrt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_W       = 31;
  localparam int ID_W        = 10;
  localparam int LIMIT_W     = 11;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int WIDE_W      = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS,
    ST_OUT
  } vidrt_state_t;

  typedef struct packed {
    logic start;
    logic scan_en;
    logic insert;
    logic load_out;
  } vidrt_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } vidrt_status_t;

endpackage

### rtl/vidrt_ctrl.sv
`timescale 1ns / 1ps

module vidrt_ctrl
  import vidrt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vidrt_status_t status,
  output vidrt_cmd_t    cmd
);

  vidrt_state_t state_r;
  vidrt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.hit) begin
          state_nxt = ST_OUT;
        end else if (status.scan_end) begin
          state_nxt = ST_MISS;
        end
      end
      ST_MISS: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      ST_MISS: begin
        cmd.insert = 1'b1;
      end
      ST_OUT: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/vidrt_datapath.sv
`timescale 1ns / 1ps

module vidrt_datapath
  import vidrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic [KEY_W-1:0]   in_vertex_key,
  input  vidrt_cmd_t         cmd,
  output vidrt_status_t      status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_dense_id,
  output logic               out_is_new,
  output logic               out_table_full
);

  logic [KEY_W-1:0]   key_store [TABLE_DEPTH];

  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   fill_r;
  logic [KEY_W-1:0]   key_r;
  logic [CNT_W-1:0]   scan_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic [CNT_W-1:0]   cmp_idx_r;
  logic               cmp_valid_r;
  logic [KEY_W-1:0]   rdata_r;
  logic [ID_W-1:0]    res_id_r;
  logic               res_new_r;
  logic               res_full_r;
  logic               out_valid_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_new_r;
  logic               out_full_r;

  logic [CNT_W-1:0]   lim_eff;
  logic [CNT_W-1:0]   scan_nxt;
  logic               issue;
  logic               room;

  // A limit above the table depth acts as the depth itself.
  always_comb begin
    if (WIDE_W'(limit_r) > WIDE_W'(TABLE_DEPTH)) begin
      lim_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      lim_eff = CNT_W'(limit_r);
    end
    scan_nxt = (fill_r < lim_eff) ? fill_r : lim_eff;
  end

  assign issue           = cmd.scan_en && (rd_idx_r != scan_r);
  assign room            = fill_r < lim_eff;
  assign status.hit      = cmd.scan_en && cmp_valid_r && (rdata_r == key_r);
  assign status.scan_end = (rd_idx_r == scan_r) && !cmp_valid_r;
  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.insert && room) begin
      fill_r <= fill_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && room) begin
      key_store[fill_r[IDX_W-1:0]] <= key_r;
    end
    if (issue) begin
      rdata_r <= key_store[rd_idx_r[IDX_W-1:0]];
    end
  end

  // Reads go out one slot per cycle; each read word is compared in the cycle after it is read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_valid_r <= 1'b0;
    end else if (cmd.start) begin
      cmp_valid_r <= 1'b0;
    end else if (cmd.scan_en) begin
      cmp_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r    <= in_vertex_key;
      scan_r   <= scan_nxt;
      rd_idx_r <= '0;
    end else if (issue) begin
      rd_idx_r  <= rd_idx_r + CNT_W'(1);
      cmp_idx_r <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (status.hit) begin
      res_id_r   <= ID_W'(cmp_idx_r);
      res_new_r  <= 1'b0;
      res_full_r <= 1'b0;
    end else if (cmd.insert) begin
      res_id_r   <= room ? ID_W'(fill_r) : '0;
      res_new_r  <= room;
      res_full_r <= !room;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_id_r   <= res_id_r;
      out_new_r  <= res_new_r;
      out_full_r <= res_full_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dense_id   = out_id_r;
  assign out_is_new     = out_new_r;
  assign out_table_full = out_full_r;

endmodule

### rtl/vertex_id_renumbering_table.sv
`timescale 1ns / 1ps
// Dense renumbering of sparse vertex keys.
// Input channel (in_valid/in_ready, in_vertex_key): one 31-bit key per
// transaction. Output channel (out_valid/out_ready): one result per key with
// out_dense_id, out_is_new and out_table_full.
// cfg_we/cfg_wdata write the slot limit; write it only while the block idles.
// The key table is a single-port-read memory scanned one slot per cycle; the
// scan covers at most the fill count of slots, up to 1024, and a hit at slot k
// ends the scan at that slot. One item is worked on at a time; in_ready is
// high only while the controller is idle, so a new key is taken only after
// the result of the last one has been loaded into the output register.
// A miss with a free slot stores the key and returns the new number with
// out_is_new set; a miss with no free slot returns zero with out_table_full.
// Reset clears the fill count and sets the limit to 1024; the key memory is
// not cleared, since only filled slots are ever read.
// If the receiver stalls, the result holds in the output register while the
// next key is still taken and searched; that key's result then waits in the
// result register, with in_ready low, until the output register frees.
module vertex_id_renumbering_table
  import vidrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KEY_W-1:0]   in_vertex_key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_dense_id,
  output logic               out_is_new,
  output logic               out_table_full
);

  vidrt_cmd_t    cmd;
  vidrt_status_t status;

  vidrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vidrt_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_vertex_key  (in_vertex_key),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dense_id   (out_dense_id),
    .out_is_new     (out_is_new),
    .out_table_full (out_table_full)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again while a key is in work");

  a_full_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_dense_id == '0) && !out_is_new)
    else $error("full result with nonzero id or new flag");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over an untaken one");

  a_hit_only_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    status.hit |=> !cmd.scan_en && !cmd.insert)
    else $error("scan or insert continued after a hit");
`endif

endmodule

### tb/sv/vertex_id_renumbering_table_test.sv
`timescale 1ns / 1ps

module vertex_id_renumbering_table_test;
  import vidrt_pkg::*;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int LONG_HOLD      = 600;
  localparam int FILL_TARGET    = 200;

  typedef struct packed {
    logic [ID_W-1:0] dense_id;
    logic            is_new;
    logic            table_full;
  } renumber_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KEY_W-1:0]   in_vertex_key = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ID_W-1:0]    out_dense_id;
  logic               out_is_new;
  logic               out_table_full;

  // Shadow copy of the block's table, fill count and limit.
  logic [KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
  int unsigned        shadow_fill = 0;
  logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;

  logic [KEY_W-1:0]   pending_keys [$];
  renumber_result_t   expected_ids [$];

  int unsigned        error_count = 0;
  int unsigned        results_seen = 0;
  int unsigned        burst_left = 0;
  int unsigned        gap_left = 0;
  int unsigned        hold_left = 0;
  bit                 hold_done = 1'b0;
  int unsigned        rx_cycle = 0;
  int unsigned        rx_mode = 0;
  int unsigned        quiet_cycles = 0;
  renumber_result_t   observed_id;
  renumber_result_t   wanted_id;

  vertex_id_renumbering_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vertex_key  (in_vertex_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dense_id   (out_dense_id),
    .out_is_new     (out_is_new),
    .out_table_full (out_table_full)
  );

  always #4 clk = ~clk;

  function automatic renumber_result_t lookup_or_insert(input logic [KEY_W-1:0] key);
    int unsigned      slots;
    int unsigned      scan;
    renumber_result_t r;
    slots = (shadow_limit > TABLE_DEPTH) ? TABLE_DEPTH : shadow_limit;
    scan  = (shadow_fill < slots) ? shadow_fill : slots;
    r     = '0;
    for (int i = 0; i < scan; i++) begin
      if (shadow_keys[i] == key) begin
        r.dense_id = ID_W'(i);
        return r;
      end
    end
    if (shadow_fill < slots) begin
      shadow_keys[shadow_fill] = key;
      r.dense_id = ID_W'(shadow_fill);
      r.is_new = 1'b1;
      shadow_fill++;
    end else begin
      r.table_full = 1'b1;
    end
    return r;
  endfunction

  task automatic offer_key(input logic [KEY_W-1:0] key);
    pending_keys.push_back(key);
    expected_ids.push_back(lookup_or_insert(key));
  endtask

  task automatic wait_idle();
    while (pending_keys.size() != 0 || expected_ids.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_limit = value;
  endtask

  function automatic logic [KEY_W-1:0] known_key();
    return shadow_keys[$urandom_range(0, shadow_fill - 1)];
  endfunction

  function automatic logic [KEY_W-1:0] edge_key();
    logic [KEY_W-1:0] one_bit;
    one_bit = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return one_bit;
      default: return ~one_bit;
    endcase
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_keys.delete(0);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_keys.size() != 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 12);
          in_valid      <= 1'b1;
          in_vertex_key <= pending_keys[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall pattern that is re-chosen at random now and again, plus one long
  // hold-off so that the block stalls its input while the sender waits.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      observed_id = '{out_dense_id, out_is_new, out_table_full};
      if (expected_ids.size() == 0) begin
        $display("%0t: unexpected result dense_id=%0d is_new=%0b table_full=%0b",
                 $time, out_dense_id, out_is_new, out_table_full);
        error_count++;
      end else begin
        wanted_id = expected_ids.pop_front();
        if (observed_id !== wanted_id) begin
          $display("%0t: expected dense_id=%0d is_new=%0b table_full=%0b,",
                   $time, wanted_id.dense_id, wanted_id.is_new,
                   wanted_id.table_full,
                   " got dense_id=%0d is_new=%0b table_full=%0b",
                   out_dense_id, out_is_new, out_table_full);
          error_count++;
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (pending_keys.size() != 0 || expected_ids.size() != 0) begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned phase_limits [9];
    int unsigned pick;
    phase_limits = '{16, 0, 40, 3, 90, 1, 150, 60, 220};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the reset limit.
    offer_key(31'h0000_0000);
    offer_key(31'h7FFF_FFFF);
    offer_key(31'h0000_0000);
    offer_key(31'h7FFF_FFFF);
    offer_key(31'h5555_5555);
    offer_key(31'h2AAA_AAAA);
    offer_key(31'h2AAA_AAAA);
    offer_key(31'h0000_0001);
    // No slot in use: everything answers full.
    write_limit(LIMIT_W'(0));
    offer_key(31'h0000_0000);
    offer_key(31'h0001_2345);
    // Limit lowered below the fill count: keys in higher slots miss.
    write_limit(LIMIT_W'(2));
    offer_key(31'h0000_0000);
    offer_key(31'h7FFF_FFFF);
    offer_key(31'h2AAA_AAAA);
    offer_key(31'h0000_0777);
    write_limit(LIMIT_W'(1));
    offer_key(31'h7FFF_FFFF);
    offer_key(31'h0000_0000);
    // Raised above the fill count again: inserts resume, then it fills up.
    write_limit(LIMIT_W'(7));
    offer_key(31'h2AAA_AAAA);
    offer_key(31'h4000_0000);
    offer_key(31'h0000_0020);
    offer_key(31'h0000_0021);
    // A limit beyond the table depth acts as the depth.
    write_limit(LIMIT_W'(2047));
    offer_key(31'h0000_0021);
    offer_key(31'h0000_0001);

    // Random part: a mix of repeated keys, fresh keys and corner keys.
    foreach (phase_limits[p]) begin
      write_limit(LIMIT_W'(phase_limits[p]));
      repeat (50) begin
        pick = $urandom_range(0, 99);
        if (pick < 55 && shadow_fill > 0) offer_key(known_key());
        else if (pick < 88) offer_key(KEY_W'($urandom()));
        else offer_key(edge_key());
      end
    end

    // Grow the table to a fixed fill, then probe the last slot and the full case.
    write_limit(LIMIT_W'(2047));
    while (shadow_fill < FILL_TARGET) begin
      if ($urandom_range(0, 9) == 0) offer_key(known_key());
      else offer_key(KEY_W'($urandom()));
    end
    write_limit(LIMIT_W'(FILL_TARGET));
    offer_key(KEY_W'($urandom()));
    offer_key(shadow_keys[FILL_TARGET - 1]);
    offer_key(shadow_keys[0]);
    offer_key(known_key());
    offer_key(edge_key());
    write_limit(LIMIT_W'(FILL_TARGET - 1));
    offer_key(shadow_keys[FILL_TARGET - 1]);
    offer_key(shadow_keys[FILL_TARGET - 2]);

    wait_idle();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/vidrt_pkg.sv
rtl/vidrt_ctrl.sv
rtl/vidrt_datapath.sv
rtl/vertex_id_renumbering_table.sv
tb/sv/vertex_id_renumbering_table_test.sv
